[rtl/core/vidfl_pkg.sv]
`default_nettype none

package vidfl_pkg;

  // Configuration port geometry.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Register index of the device started flag.
  localparam logic REG_DEVICE_STARTED = 1'b0;

  // Result status codes.
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_ENOMEM = 1'b1;

  // Input item: one filter update request.
  typedef struct packed {
    logic [11:0] vlan_id;
    logic        enable;
  } vidfl_in_t;

  // Result item: status, count after the update and restart request.
  typedef struct packed {
    logic       status;
    logic [7:0] entry_count;
    logic       restart_request;
  } vidfl_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } vidfl_state_e;

endpackage

`default_nettype wire

[rtl/core/vlan_id_filter_list_unit.sv]
`default_nettype none
// Each item is searched entry by entry (SEARCH then CMP per entry); a disable that finds its
// ID then moves the later entries down (SHIFT_RD then SHIFT_WR per entry) before DONE;
// the entries compared plus the entries moved never exceed the fill count.
// One item at a time: a new item is accepted only once the result has left the sequencer,
// which waits in DONE while the output register holds a result the consumer has not taken.
// Reset: fill count, sequencer, output valid and started flag clear at once; no clearing pass.

module vlan_id_filter_list_unit import vidfl_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel_i,
  input  wire logic               penable_i,
  input  wire logic               pwrite_i,
  input  wire logic [PADDR_W-1:0] paddr_i,
  input  wire logic [PDATA_W-1:0] pwdata_i,
  output logic      [PDATA_W-1:0] prdata_o,
  output logic                    pready_o,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire vidfl_in_t          in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output vidfl_out_t              out_data_o
);

  logic       started_q;
  logic       cfg_sel;
  logic       res_valid;
  logic       res_ready;
  vidfl_out_t res_data;
  logic       out_valid_q;
  vidfl_out_t out_q;

  // Configuration register: device started flag.
  assign pready_o = 1'b1;
  assign cfg_sel  = (paddr_i[2] == REG_DEVICE_STARTED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else if (psel_i && penable_i && pwrite_i && cfg_sel) begin
      started_q <= pwdata_i[0];
    end
  end

  assign prdata_o = cfg_sel ? {{(PDATA_W-1){1'b0}}, started_q} : '0;

  vidfl_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .started_i  (started_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_data_o (res_data)
  );

  // Output register parts the sequencer from the result consumer.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/core/vidfl_seq.sv]
`default_nettype none

module vidfl_seq import vidfl_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       started_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire vidfl_in_t  in_data_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output vidfl_out_t      res_data_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  vidfl_state_e state_q, state_d;
  logic [11:0]  id_q, id_d;
  logic         on_q, on_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] fill_q, fill_d;
  vidfl_out_t   res_q, res_d;

  // List RAM: one write and one registered read per cycle.
  logic [11:0]   mem [CAPACITY];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [11:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [11:0]   mem_rdata_q;

  logic [CW-1:0] pos_inc;

  // Truncates or extends the fill count to the 8-bit result field.
  function automatic logic [7:0] count8(input logic [CW-1:0] cnt);
    logic [CW+7:0] wide;
    wide = {8'b0, cnt};
    return wide[7:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  assign pos_inc = pos_q + CW'(1);

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    on_q  <= on_d;
    pos_q <= pos_d;
    res_q <= res_d;
  end

  // Sequencer: search with the shared comparator, then append or shift down.
  always_comb begin
    state_d   = state_q;
    id_d      = id_q;
    on_d      = on_q;
    pos_d     = pos_q;
    fill_d    = fill_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = pos_q[AW-1:0];
    mem_wdata = '0;
    mem_raddr = pos_q[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          id_d    = in_data_i.vlan_id;
          on_d    = in_data_i.enable;
          pos_d   = '0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (pos_q == fill_q) begin
          // The ID is absent from the list.
          state_d = ST_DONE;
          if (fill_q == CapCount) begin
            res_d.status          = STATUS_ENOMEM;
            res_d.entry_count     = count8(fill_q);
            res_d.restart_request = 1'b0;
          end else begin
            res_d.status          = STATUS_OK;
            res_d.restart_request = started_i;
            if (on_q) begin
              mem_we            = 1'b1;
              mem_waddr         = fill_q[AW-1:0];
              mem_wdata         = id_q;
              fill_d            = fill_q + CW'(1);
              res_d.entry_count = count8(fill_q + CW'(1));
            end else begin
              res_d.entry_count = count8(fill_q);
            end
          end
        end else begin
          mem_raddr = pos_q[AW-1:0];
          state_d   = ST_CMP;
        end
      end
      ST_CMP: begin
        if (mem_rdata_q == id_q) begin
          if (on_q) begin
            res_d.status          = STATUS_OK;
            res_d.entry_count     = count8(fill_q);
            res_d.restart_request = started_i;
            state_d               = ST_DONE;
          end else begin
            state_d = ST_SHIFT_RD;
          end
        end else begin
          pos_d   = pos_inc;
          state_d = ST_SEARCH;
        end
      end
      ST_SHIFT_RD: begin
        if (pos_inc < fill_q) begin
          mem_raddr = pos_inc[AW-1:0];
          state_d   = ST_SHIFT_WR;
        end else begin
          // Last slot is freed and cleared.
          mem_we                = 1'b1;
          mem_waddr             = pos_q[AW-1:0];
          mem_wdata             = '0;
          fill_d                = fill_q - CW'(1);
          res_d.status          = STATUS_OK;
          res_d.entry_count     = count8(fill_q - CW'(1));
          res_d.restart_request = started_i;
          state_d               = ST_DONE;
        end
      end
      ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        mem_wdata = mem_rdata_q;
        pos_d     = pos_inc;
        state_d   = ST_SHIFT_RD;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_data_o  = res_q;

`ifndef NO_ASSERTIONS
  // The fill count never passes the list capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= CapCount)
    else $error("fill count above capacity");

  // A shift step always works inside the filled part of the list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT_RD || state_q == ST_SHIFT_WR) |-> pos_q < fill_q)
    else $error("shift position outside the list");

  // A no-room result only arises with a full list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && res_q.status == STATUS_ENOMEM) |-> fill_q == CapCount)
    else $error("no room reported with free slots");

  // A transfer on the input starts the search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_SEARCH)
    else $error("accepted item did not start a search");
`endif

endmodule

`default_nettype wire
